// ===== rtl/mgrr_pkg.sv =====
// ----------------------------------------------------------------------------
// mgrr_pkg
// Shared types, widths and codes of the multi-grant round robin arbiter.
// ----------------------------------------------------------------------------
package mgrr_pkg;

  localparam int MAX_CLIENTS = 16;
  localparam int CLIENT_W    = 4;
  localparam int CNT_W       = 5;   // holds 0..MAX_CLIENTS
  localparam int DREG_W      = 5;
  localparam int DRF_W       = 2;
  localparam int CFG_W       = 5;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // result kinds
  localparam logic KIND_GRANT  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // register index (paddr[2])
  localparam logic REG_ACTIVE_CLIENTS  = 1'b0;
  localparam logic REG_GRANTS_PER_TICK = 1'b1;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);
  localparam logic [CFG_W-1:0] GRANTS_RESET = CFG_W'(1);

  typedef struct packed {
    logic                op;
    logic [CLIENT_W-1:0] client;
    logic [DREG_W-1:0]   dreg;
    logic [DRF_W-1:0]    drf;
  } cmd_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [CFG_W-1:0] limit;
  } cfg_t;

endpackage

// ===== rtl/mgrr_front.sv =====
// ----------------------------------------------------------------------------
// mgrr_front
// Register port and input classification. Requests from clients outside the
// active range are dropped here; everything else is pushed to the queue.
// ----------------------------------------------------------------------------
module mgrr_front import mgrr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [CLIENT_W-1:0] req_client_i,
  input  logic [DREG_W-1:0]   dest_register_i,
  input  logic [DRF_W-1:0]    dest_register_file_i,
  // to queue
  input  logic                q_full_i,
  output logic                q_push_o,
  output cmd_t                q_cmd_o,
  // effective configuration
  output cfg_t                cfg_o
);

  logic [CFG_W-1:0] active_q, active_d;
  logic [CFG_W-1:0] grants_q, grants_d;
  logic             wr_en;
  logic             in_range;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    active_d = active_q;
    grants_d = grants_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_ACTIVE_CLIENTS:  active_d = pwdata[CFG_W-1:0];
        REG_GRANTS_PER_TICK: grants_d = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
      grants_q <= GRANTS_RESET;
    end else begin
      active_q <= active_d;
      grants_q <= grants_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ACTIVE_CLIENTS:  prdata[CFG_W-1:0] = active_q;
      REG_GRANTS_PER_TICK: prdata[CFG_W-1:0] = grants_q;
      default: ;
    endcase
  end

  // clamp: active 0 -> 1, above MAX_CLIENTS -> MAX_CLIENTS; limit 0 -> 1
  always_comb begin
    if (active_q == '0) begin
      cfg_o.n = CNT_W'(1);
    end else if (active_q > CFG_W'(MAX_CLIENTS)) begin
      cfg_o.n = CNT_W'(MAX_CLIENTS);
    end else begin
      cfg_o.n = CNT_W'(active_q);
    end
    cfg_o.limit = (grants_q == '0) ? CFG_W'(1) : grants_q;
  end

  assign in_range   = CNT_W'(req_client_i) < cfg_o.n;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i & ((operation_i == OP_TICK) | in_range);

  assign q_cmd_o.op     = operation_i;
  assign q_cmd_o.client = req_client_i;
  assign q_cmd_o.dreg   = dest_register_i;
  assign q_cmd_o.drf    = dest_register_file_i;

endmodule

// ===== rtl/mgrr_fifo.sv =====
// ----------------------------------------------------------------------------
// mgrr_fifo
// Short command queue between the classifier and the arbitration engine.
// ----------------------------------------------------------------------------
module mgrr_fifo import mgrr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = count_q == QCNT_W'(QDEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/mgrr_back.sv =====
// ----------------------------------------------------------------------------
// mgrr_back
// Arbitration engine: pending flags, stored destinations, scan pointer and
// the result register. One grant per cycle during a tick while not stalled.
// ----------------------------------------------------------------------------
module mgrr_back import mgrr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  // from queue
  input  logic                q_empty_i,
  input  cmd_t                q_cmd_i,
  output logic                q_pop_o,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output logic [CLIENT_W-1:0] granted_client_o,
  output logic [DREG_W-1:0]   grant_register_o,
  output logic [DRF_W-1:0]    grant_register_file_o,
  output logic                last_of_run_o
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_e;

  state_e                 state_q, state_d;
  logic [MAX_CLIENTS-1:0] pend_q, pend_d;
  logic [CLIENT_W-1:0]    ptr_q, ptr_d;
  logic [CLIENT_W-1:0]    start_q, start_d;
  logic [CNT_W-1:0]       pos_q, pos_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic                   out_valid_q, out_valid_d;
  logic                   kind_q, kind_d;
  logic [CLIENT_W-1:0]    client_q, client_d;
  logic [DREG_W-1:0]      oreg_q, oreg_d;
  logic [DRF_W-1:0]       orf_q, orf_d;
  logic                   last_q, last_d;

  logic [DREG_W-1:0]      reg_mem [MAX_CLIENTS];
  logic [DRF_W-1:0]       rf_mem  [MAX_CLIENTS];

  logic                   advance;
  logic [MAX_CLIENTS-1:0] act_mask, geq_mask, cand, hi, sel_oh;
  logic [MAX_CLIENTS-1:0] flags_after, cand_after;
  logic [CLIENT_W-1:0]    pick, tick_start;
  logic [CNT_W-1:0]       cnt_inc;
  logic                   brk, last_grant, grant_fire, store_en;

  function automatic logic [CLIENT_W-1:0] lowest(input logic [MAX_CLIENTS-1:0] v);
    logic [CLIENT_W-1:0] r;
    r = '0;
    for (int i = MAX_CLIENTS - 1; i >= 0; i--) begin
      if (v[i]) r = CLIENT_W'(i);
    end
    return r;
  endfunction

  // result slot free at this edge
  assign advance = ~out_valid_q | ~out_stall_i;

  always_comb begin
    for (int i = 0; i < MAX_CLIENTS; i++) begin
      act_mask[i] = CNT_W'(i) < cfg_i.n;
      geq_mask[i] = CNT_W'(i) >= pos_q;
    end
  end

  assign cand        = pend_q & act_mask;
  assign hi          = cand & geq_mask;
  assign pick        = (|hi) ? lowest(hi) : lowest(cand);
  assign sel_oh      = MAX_CLIENTS'(1) << pick;
  assign flags_after = pend_q & ~sel_oh;
  assign cand_after  = cand & ~sel_oh;
  assign cnt_inc     = cnt_q + 1'b1;
  // stop on limit or nothing pending anywhere: pointer rests on this grant
  assign brk         = (cnt_inc >= CNT_W'(cfg_i.limit)) | (flags_after == '0);
  // otherwise the scan ends when the active range runs dry (pointer back to start)
  assign last_grant  = brk | (cand_after == '0);
  assign grant_fire  = (state_q == ST_SCAN) & advance & (|cand);
  assign tick_start  = (CNT_W'(ptr_q) >= cfg_i.n) ? '0 : ptr_q;

  assign q_pop_o     = (state_q == ST_IDLE) & ~q_empty_i & advance;
  assign store_en    = q_pop_o & (q_cmd_i.op == OP_REQUEST) & ~pend_q[q_cmd_i.client];

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    ptr_d       = ptr_q;
    start_d     = start_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    kind_d      = kind_q;
    client_d    = client_q;
    oreg_d      = oreg_q;
    orf_d       = orf_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          if (q_cmd_i.op == OP_TICK) begin
            start_d = tick_start;
            pos_d   = CNT_W'(tick_start);
            cnt_d   = '0;
            state_d = ST_SCAN;
          end else if (pend_q[q_cmd_i.client]) begin
            out_valid_d = 1'b1;
            kind_d      = KIND_REJECT;
            client_d    = q_cmd_i.client;
            oreg_d      = '0;
            orf_d       = '0;
            last_d      = 1'b1;
          end else begin
            pend_d[q_cmd_i.client] = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (advance) begin
          if (cand == '0) begin
            state_d = ST_IDLE;
          end else begin
            pend_d      = flags_after;
            cnt_d       = cnt_inc;
            pos_d       = CNT_W'(pick) + 1'b1;
            out_valid_d = 1'b1;
            kind_d      = KIND_GRANT;
            client_d    = pick;
            oreg_d      = reg_mem[pick];
            orf_d       = rf_mem[pick];
            last_d      = last_grant;
            if (last_grant) begin
              ptr_d   = brk ? pick : start_q;
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= '0;
      ptr_q       <= '0;
      start_q     <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_GRANT;
      client_q    <= '0;
      oreg_q      <= '0;
      orf_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      ptr_q       <= ptr_d;
      start_q     <= start_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      client_q    <= client_d;
      oreg_q      <= oreg_d;
      orf_q       <= orf_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      reg_mem[q_cmd_i.client] <= q_cmd_i.dreg;
      rf_mem[q_cmd_i.client]  <= q_cmd_i.drf;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign kind_o                = kind_q;
  assign granted_client_o      = client_q;
  assign grant_register_o      = oreg_q;
  assign grant_register_file_o = orf_q;
  assign last_of_run_o         = last_q;

  // a grant always targets a pending, active client
  a_grant_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grant_fire |-> ((cand & sel_oh) != '0))
    else $error("grant of a client that is not pending");

  // granted client's flag is gone on the next cycle
  a_grant_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grant_fire |=> ((pend_q & $past(sel_oh)) == '0))
    else $error("pending flag survived its grant");

  // a tick never grants beyond its limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q < CNT_W'(cfg_i.limit)))
    else $error("grant count reached limit while scanning");

  // a rejected request is always a run of one
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_REJECT) |-> last_q)
    else $error("reject result without last_of_run");

endmodule

// ===== rtl/multi_grant_round_robin_arbiter.sv =====
// ----------------------------------------------------------------------------
// multi_grant_round_robin_arbiter
// Issue arbiter for a shared unit: stores client requests, grants up to a
// configured number of pending clients per tick in round robin order.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  in       | input     | in_valid_i / in_stall_o | operation, req_client, dest_*
//  out      | output    | out_valid_o/out_stall_i | kind, granted_client, grant_*,
//           |           |                         | last_of_run
//  cfg      | input     | psel/penable/pready     | paddr[2] picks the register
//
//  A request is taken by the engine in ST_IDLE as it leaves the 2-entry queue.
//  A tick moves the engine to ST_SCAN, which makes one grant per cycle while
//  out_stall_i does not hold it; the scan in mgrr_back sets this.
//  Reset clears pending flags, scan pointer, queue and result register; the
//  stored destinations are not reset.
//  The input is taken while the engine works or a result waits, until the
//  queue is full; out_stall_i holds the result register and the engine.
// ----------------------------------------------------------------------------
module multi_grant_round_robin_arbiter import mgrr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [CLIENT_W-1:0] req_client_i,
  input  logic [DREG_W-1:0]   dest_register_i,
  input  logic [DRF_W-1:0]    dest_register_file_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output logic [CLIENT_W-1:0] granted_client_o,
  output logic [DREG_W-1:0]   grant_register_o,
  output logic [DRF_W-1:0]    grant_register_file_o,
  output logic                last_of_run_o
);

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  logic q_push, q_full, q_pop, q_empty;

  mgrr_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .operation_i          (operation_i),
    .req_client_i         (req_client_i),
    .dest_register_i      (dest_register_i),
    .dest_register_file_i (dest_register_file_i),
    .q_full_i             (q_full),
    .q_push_o             (q_push),
    .q_cmd_o              (push_cmd),
    .cfg_o                (cfg)
  );

  mgrr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  mgrr_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg),
    .q_empty_i             (q_empty),
    .q_cmd_i               (head_cmd),
    .q_pop_o               (q_pop),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .kind_o                (kind_o),
    .granted_client_o      (granted_client_o),
    .grant_register_o      (grant_register_o),
    .grant_register_file_o (grant_register_file_o),
    .last_of_run_o         (last_of_run_o)
  );

endmodule
